@@ hdl/fir_filter_causal_anticausal_defines.svh @@
// Assertion macros used by the checker file.
`ifndef FIR_FILTER_CAUSAL_ANTICAUSAL_DEFINES_SVH
`define FIR_FILTER_CAUSAL_ANTICAUSAL_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define FCAC_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while in reset.
`define FCAC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hdl/fcac_pkg.sv @@
package fcac_pkg;

	localparam int TAPS       = 7;
	localparam int HIST       = TAPS - 1;
	localparam int SAMPLE_W   = 32;
	localparam int COEF_W     = 16;
	localparam int FRAC_BITS  = 14;
	localparam int PROD_W     = SAMPLE_W + COEF_W;
	localparam int ACC_W      = PROD_W + $clog2(TAPS + 1);
	localparam int QUO_W      = ACC_W - FRAC_BITS;
	localparam int SPLIT      = (TAPS + 1) / 2;
	localparam int SEEN_W     = $clog2(TAPS);
	localparam int LEFT_W     = $clog2(TAPS + 1);
	localparam int RING_AW    = $clog2(TAPS + 1);
	localparam int RING_DEPTH = 2 ** RING_AW;
	localparam int MODE_W     = 2;
	localparam int CFG_IDX_W  = $clog2(TAPS + 1);

	localparam logic [SEEN_W-1:0]   SEEN_FULL  = SEEN_W'(HIST);
	localparam logic [ACC_W-1:0]    FRAC_MASK  = ACC_W'((2 ** FRAC_BITS) - 1);
	localparam logic [SAMPLE_W-1:0] SAT_MAX    = {1'b0, {(SAMPLE_W - 1){1'b1}}};
	localparam logic [SAMPLE_W-1:0] SAT_MIN    = {1'b1, {(SAMPLE_W - 1){1'b0}}};
	localparam logic [COEF_W-1:0]   COEF0_INIT = COEF_W'(2 ** FRAC_BITS);

	localparam logic [CFG_IDX_W-1:0] REG_MODE  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_COEF0 = CFG_IDX_W'(1);

	typedef enum logic [MODE_W-1:0] {
		MODE_PAST   = 2'd0,
		MODE_FUTURE = 2'd1,
		MODE_BYPASS = 2'd2
	} mode_t;

	typedef logic [HIST-1:0][SAMPLE_W-1:0] hist_t;
	typedef logic [TAPS-1:0][SAMPLE_W-1:0] win_t;
	typedef logic [TAPS-1:0][COEF_W-1:0]   coef_arr_t;

	// item leaving the history stage
	typedef struct packed {
		logic                valid;
		logic                last;
		logic [SEEN_W-1:0]   seen;
		logic [SAMPLE_W-1:0] x;
	} s1_t;

	// control riding with a window into the multiply-add pipe
	typedef struct packed {
		logic valid;
		logic fin;
		logic byp;
	} mac_ctl_t;

	// finished result
	typedef struct packed {
		logic                valid;
		logic                fin;
		logic [SAMPLE_W-1:0] value;
	} res_t;

endpackage

@@ hdl/fcac_ram.sv @@
module fcac_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ hdl/fcac_hist.sv @@
module fcac_hist (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          accept,
	input  logic [fcac_pkg::SAMPLE_W-1:0] sample,
	input  logic                          block_end,
	input  logic                          s1_move,
	output fcac_pkg::s1_t                 s1,
	output fcac_pkg::hist_t               hist
);
	import fcac_pkg::*;

	logic [RING_AW-1:0]  ptr_q;
	logic [SEEN_W-1:0]   seen_q;
	logic                valid_s1;
	logic                last_s1;
	logic [SEEN_W-1:0]   seen_s1;
	logic [SAMPLE_W-1:0] x_s1;

	// one delay-line memory per older tap, all written with the same sample
	for (genvar d = 1; d <= HIST; d++) begin : g_tap
		fcac_ram #(
			.WIDTH(SAMPLE_W),
			.DEPTH(RING_DEPTH)
		) u_ring (
			.clk  (clk),
			.we   (accept),
			.waddr(ptr_q),
			.wdata(sample),
			.re   (accept),
			.raddr(ptr_q - RING_AW'(d)),
			.rdata(hist[d-1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q    <= '0;
			seen_q   <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (accept) begin
				ptr_q <= ptr_q + RING_AW'(1);
				if (block_end) begin
					seen_q <= '0;
				end else if (seen_q < SEEN_FULL) begin
					seen_q <= seen_q + SEEN_W'(1);
				end
			end
			valid_s1 <= accept | (valid_s1 & ~s1_move);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			last_s1 <= block_end;
			seen_s1 <= seen_q;
			x_s1    <= sample;
		end
	end

	assign s1 = '{valid: valid_s1, last: last_s1, seen: seen_s1, x: x_s1};

endmodule

@@ hdl/fcac_win.sv @@
module fcac_win (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        adv,
	input  logic [fcac_pkg::MODE_W-1:0] mode,
	input  fcac_pkg::s1_t               s1,
	input  fcac_pkg::hist_t             hist,
	output logic                        busy,
	output fcac_pkg::mac_ctl_t          ctl,
	output fcac_pkg::win_t              win
);
	import fcac_pkg::*;

	logic              win_valid_q;
	logic [LEFT_W-1:0] win_left_q;
	logic              win_fin_q;
	logic              win_byp_q;
	win_t              win_v_q;

	win_t              ld_v;
	logic [LEFT_W-1:0] ld_n;
	logic              ld_byp;
	logic [SEEN_W-1:0] idx;

	// window and result count for the item in the history stage
	always_comb begin
		ld_v   = '0;
		ld_n   = LEFT_W'(1);
		ld_byp = 1'b0;
		idx    = '0;
		unique case (mode)
			MODE_PAST: begin
				ld_v[0] = s1.x;
				for (int k = 1; k < TAPS; k++) begin
					if (SEEN_W'(k) <= s1.seen) begin
						ld_v[k] = hist[k-1];
					end
				end
			end
			MODE_FUTURE: begin
				// oldest held sample first, current sample after it
				for (int y = 0; y < TAPS; y++) begin
					idx = s1.seen - SEEN_W'(y) - SEEN_W'(1);
					if (SEEN_W'(y) < s1.seen) begin
						ld_v[y] = hist[idx];
					end else if (SEEN_W'(y) == s1.seen) begin
						ld_v[y] = s1.x;
					end
				end
				if (s1.last) begin
					ld_n = LEFT_W'(s1.seen) + LEFT_W'(1);
				end else if (s1.seen == SEEN_FULL) begin
					ld_n = LEFT_W'(1);
				end else begin
					ld_n = '0;
				end
			end
			default: begin
				ld_v[0] = s1.x;
				ld_byp  = 1'b1;
			end
		endcase
	end

	assign busy = win_valid_q && (win_left_q > LEFT_W'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_valid_q <= 1'b0;
			win_left_q  <= '0;
		end else if (adv) begin
			if (busy) begin
				win_left_q <= win_left_q - LEFT_W'(1);
			end else if (s1.valid) begin
				win_valid_q <= (ld_n != '0);
				win_left_q  <= ld_n;
			end else begin
				win_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (busy) begin
				// drop the front sample, pad zero behind the block end
				for (int y = 0; y < TAPS - 1; y++) begin
					win_v_q[y] <= win_v_q[y+1];
				end
				win_v_q[TAPS-1] <= '0;
			end else if (s1.valid) begin
				win_v_q   <= ld_v;
				win_fin_q <= s1.last;
				win_byp_q <= ld_byp;
			end
		end
	end

	assign ctl = '{
		valid: win_valid_q,
		fin:   win_fin_q && (win_left_q == LEFT_W'(1)),
		byp:   win_byp_q
	};
	assign win = win_v_q;

endmodule

@@ hdl/fcac_mac.sv @@
module fcac_mac (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 adv,
	input  fcac_pkg::coef_arr_t  coef,
	input  fcac_pkg::mac_ctl_t   ctl,
	input  fcac_pkg::win_t       win,
	output fcac_pkg::res_t       res
);
	import fcac_pkg::*;

	logic signed [PROD_W-1:0] prod_s3 [TAPS];
	mac_ctl_t                 ctl_s3;
	logic [SAMPLE_W-1:0]      x_s3;

	logic signed [ACC_W-1:0]  part_a_s4;
	logic signed [ACC_W-1:0]  part_b_s4;
	mac_ctl_t                 ctl_s4;
	logic [SAMPLE_W-1:0]      x_s4;

	logic signed [ACC_W-1:0]  acc_s5;
	mac_ctl_t                 ctl_s5;
	logic [SAMPLE_W-1:0]      x_s5;

	logic signed [ACC_W-1:0]  sum_a;
	logic signed [ACC_W-1:0]  sum_b;
	logic signed [ACC_W-1:0]  biased;
	logic [QUO_W-1:0]         quo;
	logic                     sat_hi;
	logic                     sat_lo;
	logic [SAMPLE_W-1:0]      value;

	always_comb begin
		sum_a = '0;
		sum_b = '0;
		for (int y = 0; y < SPLIT; y++) begin
			sum_a = sum_a + ACC_W'(prod_s3[y]);
		end
		for (int y = SPLIT; y < TAPS; y++) begin
			sum_b = sum_b + ACC_W'(prod_s3[y]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s3 <= '0;
			ctl_s4 <= '0;
			ctl_s5 <= '0;
		end else if (adv) begin
			ctl_s3 <= ctl;
			ctl_s4 <= ctl_s3;
			ctl_s5 <= ctl_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int y = 0; y < TAPS; y++) begin
				prod_s3[y] <= $signed(win[y]) * $signed(coef[y]);
			end
			x_s3      <= win[0];
			part_a_s4 <= sum_a;
			part_b_s4 <= sum_b;
			x_s4      <= x_s3;
			acc_s5    <= part_a_s4 + part_b_s4;
			x_s5      <= x_s4;
		end
	end

	// truncate toward zero, then clamp to the sample range
	always_comb begin
		biased = acc_s5 + (acc_s5[ACC_W-1] ? FRAC_MASK : '0);
		quo    = biased[ACC_W-1:FRAC_BITS];
		sat_hi = !quo[QUO_W-1] && (|quo[QUO_W-2:SAMPLE_W-1]);
		sat_lo = quo[QUO_W-1] && !(&quo[QUO_W-2:SAMPLE_W-1]);
		priority if (ctl_s5.byp) begin
			value = x_s5;
		end else if (sat_hi) begin
			value = SAT_MAX;
		end else if (sat_lo) begin
			value = SAT_MIN;
		end else begin
			value = quo[SAMPLE_W-1:0];
		end
	end

	assign res = '{valid: ctl_s5.valid, fin: ctl_s5.fin, value: value};

endmodule

@@ hdl/fir_filter_causal_anticausal.sv @@
// Block FIR filter, seven taps, with past, future and bypass modes. An item is
// taken every cycle unless the input stalls, and its result passes the history
// register, the window register, the multiply stage, two adder stages and the
// result register. A future-mode item that ends a block releases every pending
// result, up to seven, one per cycle from the window sequencer unless the pipe
// is held; meanwhile the input takes at most one more item and then stalls. The
// sample history lives in six small delay-line memories (one per older tap) that
// need no clearing pass: a per-block fill count masks entries left from earlier blocks.
module fir_filter_causal_anticausal (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [fcac_pkg::SAMPLE_W-1:0]  sample,
	input  logic                           block_end,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [fcac_pkg::SAMPLE_W-1:0]  filtered,
	output logic                           final_result,
	input  logic                           cfg_wr_en,
	input  logic [fcac_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [fcac_pkg::COEF_W-1:0]    cfg_data
);
	import fcac_pkg::*;

	logic [MODE_W-1:0]   mode_q;
	coef_arr_t           coef_q;

	logic                adv;
	logic                accept;
	logic                win_busy;
	logic                s1_move;
	s1_t                 s1;
	hist_t               hist;
	mac_ctl_t            ctl;
	win_t                win;
	res_t                res;

	logic                out_valid_q;
	logic                out_fin_q;
	logic [SAMPLE_W-1:0] out_value_q;
	logic                skid_valid_q;
	logic                skid_fin_q;
	logic [SAMPLE_W-1:0] skid_value_q;

	logic                push;
	logic                out_from_skid;
	logic                out_from_push;
	logic                skid_load;

	// Configuration registers; the user must write them only while the block is idle, which the block does not enforce.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_BYPASS;
			coef_q <= {{((TAPS - 1) * COEF_W){1'b0}}, COEF0_INIT};
		end else if (cfg_wr_en) begin
			if (cfg_index == REG_MODE) begin
				mode_q <= cfg_data[MODE_W-1:0];
			end else begin
				coef_q[cfg_index - REG_COEF0] <= cfg_data;
			end
		end
	end

	// The whole pipe advances unless the skid slot is full. Both terms come from
	// registers, so the output stall has no combinational path to the input stall.
	assign adv      = !skid_valid_q;
	assign s1_move  = adv && !win_busy;
	assign in_stall = !adv || (s1.valid && win_busy);
	assign accept   = in_valid && !in_stall;

	// Write the new sample into the tap memories and read the six older ones.
	fcac_hist u_hist (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.sample   (sample),
		.block_end(block_end),
		.s1_move  (s1_move),
		.s1       (s1),
		.hist     (hist)
	);

	// Build the tap window and issue one, none or a flush of results.
	fcac_win u_win (
		.clk   (clk),
		.arst_n(arst_n),
		.adv   (adv),
		.mode  (mode_q),
		.s1    (s1),
		.hist  (hist),
		.busy  (win_busy),
		.ctl   (ctl),
		.win   (win)
	);

	// Multiply, add, scale and clamp.
	fcac_mac u_mac (
		.clk   (clk),
		.arst_n(arst_n),
		.adv   (adv),
		.coef  (coef_q),
		.ctl   (ctl),
		.win   (win),
		.res   (res)
	);

	// Output register plus one skid slot: a result pushed while the output is
	// stalled parks in the skid, which then holds the pipe until it drains.
	assign push          = adv && res.valid;
	assign out_from_skid = skid_valid_q && !out_stall;
	assign out_from_push = push && (!out_valid_q || !out_stall);
	assign skid_load     = push && out_valid_q && out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (out_from_skid) begin
				skid_valid_q <= 1'b0;
			end else if (skid_load) begin
				skid_valid_q <= 1'b1;
			end
			if (out_from_skid || out_from_push) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_from_skid) begin
			out_value_q <= skid_value_q;
			out_fin_q   <= skid_fin_q;
		end else if (out_from_push) begin
			out_value_q <= res.value;
			out_fin_q   <= res.fin;
		end
		if (skid_load) begin
			skid_value_q <= res.value;
			skid_fin_q   <= res.fin;
		end
	end

	assign out_valid    = out_valid_q;
	assign filtered     = out_value_q;
	assign final_result = out_fin_q;

endmodule

@@ hdl/fcac_checker.sv @@
`include "fir_filter_causal_anticausal_defines.svh"

module fcac_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_stall,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic [fcac_pkg::SAMPLE_W-1:0] filtered,
	input logic                          final_result
);

	// a stalled result stays offered
	`FCAC_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid, "result dropped while stalled")

	// and does not change under a stall
	`FCAC_ASSERT_NEXT(a_out_stable, clk, arst_n, out_valid && out_stall, $stable(filtered) && $stable(final_result), "stalled result changed")

	// nothing comes out right after reset
	`FCAC_ASSERT_SAME(a_rst_quiet, clk, arst_n, $rose(arst_n), !out_valid, "result offered out of reset")

	// the block is ready for an item right after reset
	`FCAC_ASSERT_SAME(a_rst_ready, clk, arst_n, $rose(arst_n) && in_valid, !in_stall, "input stalled out of reset")

endmodule

bind fir_filter_causal_anticausal fcac_checker u_fcac_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_stall    (in_stall),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.filtered    (filtered),
	.final_result(final_result)
);

@@ tb/sv/fir_filter_causal_anticausal_tb.sv @@
`timescale 1ns / 1ps

// Block FIR testbench: a directed table walk, then random configuration
// phases with random blocks of samples. Every accepted item runs through a
// local fixed-point filter that queues the outputs it should cause. Every
// accepted output is compared against the oldest queued entry.
module fir_filter_causal_anticausal_tb;
	import fcac_pkg::*;

	// the mode register is two bits wide; the fourth code has no enum member
	localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

	localparam int SETTLE_CYCLES = 16;   // pipe depth plus a full flush burst
	localparam int HOLD_CYCLES   = 150;  // long output hold-off, once per run
	localparam int STUCK_LIMIT   = 1000; // cycles with no handshake at all
	localparam int RANDOM_ITEMS  = 420;
	localparam int PRINT_LIMIT   = 40;
	localparam int SIDE_SEND     = 0;
	localparam int SIDE_RECV     = 1;
	localparam int PLAN_ROWS     = 40;

	typedef enum logic [1:0] {
		ROW_WRITE,
		ROW_ITEM,
		ROW_TYPED
	} row_kind_t;

	// one row of the directed walk; want/want_fin are only used by typed rows
	typedef struct packed {
		row_kind_t              kind;
		logic [CFG_IDX_W-1:0]   reg_idx;
		logic [SAMPLE_W-1:0]    value;
		logic                   last;
		logic [SAMPLE_W-1:0]    want;
		logic                   want_fin;
	} plan_row_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] value;
		logic                fin;
	} filt_out_t;

	localparam plan_row_t PLAN [PLAN_ROWS] = '{
		// bypass right after reset: the sample comes back untouched
		'{ROW_TYPED, REG_MODE, 32'h7FFFFFFF, 1'b0, 32'h7FFFFFFF, 1'b0},
		'{ROW_TYPED, REG_MODE, 32'h80000000, 1'b1, 32'h80000000, 1'b1},
		// spare mode code behaves as bypass
		'{ROW_WRITE, REG_MODE, 32'(MODE_SPARE), 1'b0, 32'h0, 1'b0},
		'{ROW_TYPED, REG_MODE, 32'h5A5A5A5A, 1'b0, 32'h5A5A5A5A, 1'b0},
		'{ROW_TYPED, REG_MODE, 32'hA5A5A5A5, 1'b1, 32'hA5A5A5A5, 1'b1},
		// past mode, weight -2.0 on full-scale samples: both rails saturate
		'{ROW_WRITE, REG_MODE, 32'(MODE_PAST), 1'b0, 32'h0, 1'b0},
		'{ROW_WRITE, REG_COEF0, 32'h8000, 1'b0, 32'h0, 1'b0},
		'{ROW_TYPED, REG_MODE, 32'h80000000, 1'b0, 32'h7FFFFFFF, 1'b0},
		'{ROW_TYPED, REG_MODE, 32'h7FFFFFFF, 1'b1, 32'h80000000, 1'b1},
		// smallest weight: quotients truncate toward zero
		'{ROW_WRITE, REG_COEF0, 32'h0001, 1'b0, 32'h0, 1'b0},
		'{ROW_TYPED, REG_MODE, 32'hFFFFFFFF, 1'b0, 32'h00000000, 1'b0},
		'{ROW_TYPED, REG_MODE, 32'hFFFFBFFF, 1'b0, 32'hFFFFFFFF, 1'b0},
		'{ROW_TYPED, REG_MODE, 32'h00004000, 1'b1, 32'h00000001, 1'b1},
		// all seven taps loaded with extremes and odd values
		'{ROW_WRITE, REG_COEF0, 32'h7FFF, 1'b0, 32'h0, 1'b0},
		'{ROW_WRITE, CFG_IDX_W'(REG_COEF0 + 1), 32'h4000, 1'b0, 32'h0, 1'b0},
		'{ROW_WRITE, CFG_IDX_W'(REG_COEF0 + 2), 32'hC000, 1'b0, 32'h0, 1'b0},
		'{ROW_WRITE, CFG_IDX_W'(REG_COEF0 + 3), 32'h8000, 1'b0, 32'h0, 1'b0},
		'{ROW_WRITE, CFG_IDX_W'(REG_COEF0 + 4), 32'h7FFF, 1'b0, 32'h0, 1'b0},
		'{ROW_WRITE, CFG_IDX_W'(REG_COEF0 + 5), 32'h0001, 1'b0, 32'h0, 1'b0},
		'{ROW_WRITE, CFG_IDX_W'(REG_COEF0 + 6), 32'hE000, 1'b0, 32'h0, 1'b0},
		'{ROW_ITEM, REG_MODE, 32'h7FFFFFFF, 1'b0, 32'h0, 1'b0},
		'{ROW_ITEM, REG_MODE, 32'h80000000, 1'b0, 32'h0, 1'b0},
		'{ROW_ITEM, REG_MODE, 32'h00000001, 1'b0, 32'h0, 1'b0},
		'{ROW_ITEM, REG_MODE, 32'h7FFFFFFF, 1'b0, 32'h0, 1'b0},
		'{ROW_ITEM, REG_MODE, 32'h12345678, 1'b1, 32'h0, 1'b0},
		// future mode: a block longer than the taps, then a one-sample block
		'{ROW_WRITE, REG_MODE, 32'(MODE_FUTURE), 1'b0, 32'h0, 1'b0},
		'{ROW_ITEM, REG_MODE, 32'h7FFFFFFF, 1'b0, 32'h0, 1'b0},
		'{ROW_ITEM, REG_MODE, 32'h80000000, 1'b0, 32'h0, 1'b0},
		'{ROW_ITEM, REG_MODE, 32'h7FFFFFFF, 1'b0, 32'h0, 1'b0},
		'{ROW_ITEM, REG_MODE, 32'h80000000, 1'b0, 32'h0, 1'b0},
		'{ROW_ITEM, REG_MODE, 32'hDEADBEEF, 1'b0, 32'h0, 1'b0},
		'{ROW_ITEM, REG_MODE, 32'h00000000, 1'b0, 32'h0, 1'b0},
		'{ROW_ITEM, REG_MODE, 32'h7FFFFFFF, 1'b0, 32'h0, 1'b0},
		'{ROW_ITEM, REG_MODE, 32'h0F0F0F0F, 1'b1, 32'h0, 1'b0},
		'{ROW_ITEM, REG_MODE, 32'h80000000, 1'b1, 32'h0, 1'b0},
		// switch to past mode in the middle of a block
		'{ROW_ITEM, REG_MODE, 32'h11111111, 1'b0, 32'h0, 1'b0},
		'{ROW_ITEM, REG_MODE, 32'hEEEEEEEE, 1'b0, 32'h0, 1'b0},
		'{ROW_WRITE, REG_MODE, 32'(MODE_PAST), 1'b0, 32'h0, 1'b0},
		'{ROW_ITEM, REG_MODE, 32'h22222222, 1'b0, 32'h0, 1'b0},
		'{ROW_ITEM, REG_MODE, 32'h7FFFFFFF, 1'b1, 32'h0, 1'b0}
	};

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_stall;
	logic [SAMPLE_W-1:0]  sample;
	logic                 block_end;
	logic                 out_valid;
	logic                 out_stall;
	logic [SAMPLE_W-1:0]  filtered;
	logic                 final_result;
	logic                 cfg_wr_en;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [COEF_W-1:0]    cfg_data;

	// local copy of the filter: registers, history and pending outputs
	logic [MODE_W-1:0]         mode_reg;
	logic signed [COEF_W-1:0]  coef_reg [TAPS];
	logic signed [SAMPLE_W-1:0] past_samples [HIST];  // newest first
	int                        held_count;
	filt_out_t                 pending_outputs [$];

	// typed expectation riding with the item currently offered
	logic                row_typed;
	logic [SAMPLE_W-1:0] row_want;
	logic                row_want_fin;

	logic hold_off_req = 1'b0;
	int   calm_left [2] = '{0, 0};
	int   mismatches = 0;
	int   items_sent = 0;
	int   results_checked = 0;
	int   blocks_closed = 0;
	int   settings_applied = 0;
	int   holds_done = 0;
	int   stuck_cycles = 0;
	int   mode_items [4] = '{0, 0, 0, 0};

	fir_filter_causal_anticausal dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.sample       (sample),
		.block_end    (block_end),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.filtered     (filtered),
		.final_result (final_result),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	task automatic report_mismatch(input string what);
		mismatches++;
		if (mismatches <= PRINT_LIMIT)
			$display("MISMATCH at %0t ns: %s", $time, what);
	endtask

	// Draw a random idle gap per item, with occasional runs of back-to-back items.
	function automatic int draw_gap(input int side);
		if (calm_left[side] != 0) begin
			calm_left[side]--;
			return 0;
		end
		if ($urandom_range(0, 15) == 0) begin
			calm_left[side] = $urandom_range(20, 60);
			return 0;
		end
		return ($urandom_range(0, 1) != 0) ? 0 : $urandom_range(1, 13);
	endfunction

	// Divide by 2^14 toward zero, then clamp to the 32-bit range.
	function automatic logic [SAMPLE_W-1:0] scale_sat(input longint acc);
		longint q;
		q = acc / (longint'(1) << FRAC_BITS);
		if (q > longint'($signed(SAT_MAX)))
			return SAT_MAX;
		if (q < longint'($signed(SAT_MIN)))
			return SAT_MIN;
		return q[SAMPLE_W-1:0];
	endfunction

	// Future-mode sum: tap y weights win[first + y], nothing past win[m-1].
	function automatic logic [SAMPLE_W-1:0] window_sum(
		input logic signed [SAMPLE_W-1:0] win [TAPS], input int first, input int m);
		longint acc;
		int     y;
		acc = 0;
		for (y = 0; y < TAPS; y++) begin
			if (first + y < m)
				acc += longint'(coef_reg[y]) * longint'(win[first + y]);
		end
		return scale_sat(acc);
	endfunction

	// Queue the outputs one accepted item causes, then advance the history.
	function automatic void filter_sample(input logic [SAMPLE_W-1:0] x, input logic last);
		logic signed [SAMPLE_W-1:0] win [TAPS];
		longint                     acc;
		int                         m;
		int                         k;
		int                         j;
		filt_out_t                  r;
		case (mode_reg)
			MODE_PAST: begin
				acc = longint'(coef_reg[0]) * longint'($signed(x));
				for (k = 1; k < TAPS; k++)
					acc += longint'(coef_reg[k]) * longint'(past_samples[k - 1]);
				r.value = scale_sat(acc);
				r.fin   = last;
				pending_outputs.push_back(r);
			end
			MODE_FUTURE: begin
				// oldest sample of the block sits at win[0], this one at win[m-1]
				for (k = 0; k < TAPS; k++)
					win[k] = '0;
				m = held_count + 1;
				for (k = 1; k <= held_count; k++)
					win[m - 1 - k] = past_samples[k - 1];
				win[m - 1] = x;
				if (!last) begin
					if (m == TAPS) begin
						r.value = window_sum(win, 0, m);
						r.fin   = 1'b0;
						pending_outputs.push_back(r);
					end
				end else begin
					// block end flushes every window still open
					for (j = 0; j < m; j++) begin
						r.value = window_sum(win, j, m);
						r.fin   = (j == m - 1);
						pending_outputs.push_back(r);
					end
				end
			end
			default: begin
				// bypass and the spare code
				r.value = x;
				r.fin   = last;
				pending_outputs.push_back(r);
			end
		endcase
		if (last) begin
			for (k = 0; k < HIST; k++)
				past_samples[k] = '0;
			held_count = 0;
		end else begin
			for (k = HIST - 1; k > 0; k--)
				past_samples[k] = past_samples[k - 1];
			past_samples[0] = x;
			if (held_count < HIST)
				held_count++;
		end
	endfunction

	// Drop valid, wait until every queued output has arrived, then let the
	// pipe drain items that cause no output before touching registers.
	task automatic quiesce();
		in_valid <= 1'b0;
		while (pending_outputs.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Present one write for a single edge; the caller lowers the enable.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] data);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(negedge clk);
	endtask

	// Offer one item after a random gap and hold it until it is taken.
	task automatic send_item(input logic [SAMPLE_W-1:0] value, input logic last,
		input logic typed, input logic [SAMPLE_W-1:0] want, input logic want_fin);
		int gap;
		gap = draw_gap(SIDE_SEND);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		sample       <= value;
		block_end    <= last;
		in_valid     <= 1'b1;
		row_typed    = typed;
		row_want     = want;
		row_want_fin = want_fin;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		items_sent++;
		@(negedge clk);
	endtask

	// Output side: draw a hold-off per output, or the one long hold when asked.
	initial begin : drain
		int gap;
		out_stall = 1'b1;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				gap = HOLD_CYCLES;
				hold_off_req = 1'b0;
				holds_done++;
			end else begin
				gap = draw_gap(SIDE_RECV);
			end
			if (gap != 0) begin
				out_stall <= 1'b1;
				repeat (gap) @(negedge clk);
			end
			out_stall <= 1'b0;
			@(posedge clk);
			while (!out_valid)
				@(posedge clk);
		end
	end

	// Sample both handshakes and the write port at the rising edge: predict
	// on input acceptance, compare on output acceptance, and watch for hangs.
	always @(posedge clk) begin : watch
		filt_out_t want_r;
		int        depth;
		int        k;
		logic      moved;
		if (!arst_n) begin
			// mirror the block's reset values
			mode_reg = MODE_BYPASS;
			coef_reg[0] = COEF0_INIT;
			for (k = 1; k < TAPS; k++)
				coef_reg[k] = '0;
			for (k = 0; k < HIST; k++)
				past_samples[k] = '0;
			held_count = 0;
		end else begin
			moved = 1'b0;
			if (cfg_wr_en) begin
				if (cfg_index == REG_MODE)
					mode_reg = cfg_data[MODE_W-1:0];
				else
					coef_reg[cfg_index - REG_COEF0] = cfg_data;
			end
			if (in_valid && !in_stall) begin
				moved = 1'b1;
				mode_items[mode_reg]++;
				depth = pending_outputs.size();
				filter_sample(sample, block_end);
				if (row_typed) begin
					// swap in the hand-written value for this row
					while (pending_outputs.size() > depth)
						void'(pending_outputs.pop_back());
					want_r.value = row_want;
					want_r.fin   = row_want_fin;
					pending_outputs.push_back(want_r);
				end
			end
			if (out_valid && !out_stall) begin
				moved = 1'b1;
				if (pending_outputs.size() == 0) begin
					report_mismatch($sformatf("output %h final %b with nothing pending",
						filtered, final_result));
				end else begin
					want_r = pending_outputs.pop_front();
					if (filtered !== want_r.value)
						report_mismatch($sformatf("filtered %h, predicted %h",
							filtered, want_r.value));
					if (final_result !== want_r.fin)
						report_mismatch($sformatf("final_result %b, predicted %b (filtered %h)",
							final_result, want_r.fin, want_r.value));
					results_checked++;
					if (want_r.fin)
						blocks_closed++;
				end
			end
			stuck_cycles = moved ? 0 : stuck_cycles + 1;
			if (stuck_cycles >= STUCK_LIMIT) begin
				$display("watchdog: no handshake for %0d cycles, %0d outputs pending",
					STUCK_LIMIT, pending_outputs.size());
				$display("simulation failed");
				$finish;
			end
		end
	end

	initial begin : stimulus
		plan_row_t           row;
		logic                writing;
		logic [MODE_W-1:0]   new_mode;
		logic [COEF_W-1:0]   cval;
		logic [SAMPLE_W-1:0] value;
		int                  i;
		int                  k;
		int                  pick;
		int                  taps;
		int                  count;
		int                  block_left;
		int                  phase;
		int                  random_sent;

		arst_n       = 1'b0;
		in_valid     = 1'b0;
		sample       = '0;
		block_end    = 1'b0;
		cfg_wr_en    = 1'b0;
		cfg_index    = '0;
		cfg_data     = '0;
		row_typed    = 1'b0;
		row_want     = '0;
		row_want_fin = 1'b0;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;

		// Directed walk: a run of write rows is one register setting, taken
		// only once the block has gone idle.
		writing = 1'b0;
		for (i = 0; i < PLAN_ROWS; i++) begin
			row = PLAN[i];
			if (row.kind == ROW_WRITE) begin
				if (!writing) begin
					quiesce();
					settings_applied++;
				end
				writing = 1'b1;
				write_reg(row.reg_idx, row.value[COEF_W-1:0]);
			end else begin
				if (writing)
					cfg_wr_en <= 1'b0;
				writing = 1'b0;
				send_item(row.value, row.last, row.kind == ROW_TYPED, row.want, row.want_fin);
			end
		end

		// Random phases: new mode and weights, then a run of blocks. A phase
		// may stop mid-block, so the next setting lands inside an open block.
		phase       = 0;
		random_sent = 0;
		block_left  = 0;
		while (random_sent < RANDOM_ITEMS) begin
			quiesce();
			settings_applied++;
			pick = $urandom_range(0, 19);
			if (phase == 2 || (pick >= 7 && pick < 15))
				new_mode = MODE_FUTURE;
			else if (pick < 7)
				new_mode = MODE_PAST;
			else if (pick < 18)
				new_mode = MODE_BYPASS;
			else
				new_mode = MODE_SPARE;
			write_reg(REG_MODE, COEF_W'(new_mode));
			// sometimes emulate a shorter filter by zeroing the upper taps
			taps = ($urandom_range(0, 3) == 0) ? $urandom_range(1, TAPS) : TAPS;
			for (k = 0; k < TAPS; k++) begin
				if (k >= taps) begin
					write_reg(CFG_IDX_W'(REG_COEF0 + k), '0);
				end else if (phase == 0 || $urandom_range(0, 1) != 0) begin
					case ($urandom_range(0, 3))
						0: cval = ($urandom_range(0, 1) != 0) ? 16'h7FFF : 16'h8000;
						1: cval = COEF_W'($urandom_range(0, 1024) - 512);
						default: cval = COEF_W'($urandom);
					endcase
					write_reg(CFG_IDX_W'(REG_COEF0 + k), cval);
				end
			end
			cfg_wr_en <= 1'b0;

			// one future-mode phase runs long under a held-off output
			count = $urandom_range(8, 40);
			if (phase == 2) begin
				hold_off_req = 1'b1;
				count = 60;
			end
			repeat (count) begin
				if (block_left == 0) begin
					pick = $urandom_range(0, 9);
					if (pick == 0)
						block_left = 1;
					else if (pick < 7)
						block_left = $urandom_range(2, 9);
					else
						block_left = $urandom_range(10, 24);
				end
				block_left--;
				case ($urandom_range(0, 7))
					0: value = SAT_MAX;
					1: value = SAT_MIN;
					2, 3: value = $urandom_range(0, 200000) - 100000;
					default: value = $urandom;
				endcase
				send_item(value, block_left == 0, 1'b0, '0, 1'b0);
				random_sent++;
			end
			phase++;
		end

		// Drain everything, then give late strays time to show up.
		quiesce();
		$display("Covered %0d items (past %0d, future %0d, bypass %0d, spare code %0d)",
			items_sent, mode_items[MODE_PAST], mode_items[MODE_FUTURE],
			mode_items[MODE_BYPASS], mode_items[MODE_SPARE]);
		$display("Checked %0d outputs, %0d block ends, %0d register settings, %0d long holds",
			results_checked, blocks_closed, settings_applied, holds_done);
		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
